@@ rtl/cross_id_binary_search_defines.svh @@
// ----------------------------------------------------------------------------
// Cross-identifier binary search: assertion macros
// Shared property forms; clock aclk, assertions disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CROSS_ID_BINARY_SEARCH_DEFINES_SVH
`define CROSS_ID_BINARY_SEARCH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CIBS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CIBS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cibs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-identifier binary search: shared package
// Field widths, register indexes, item codes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cibs_pkg;

    localparam int ID_W                = 63;
    localparam int SLOT_W              = 12;
    localparam int SEL_W               = 2;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 13;
    localparam int DEFAULT_TABLE_DEPTH = 4096;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLUMN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COLUMN = 2'd2;

    // Item kinds.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Column selectors; any other code selects the third column.
    localparam logic [SEL_W-1:0] COL_FIRST  = 2'd0;
    localparam logic [SEL_W-1:0] COL_SECOND = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } cibs_state_t;

    typedef struct packed {
        logic load_row;   // write the incoming row into the table
        logic start;      // open the search window for a new lookup
        logic step;       // compare the probed row and narrow the window
        logic out_load;   // move the finished result into the output register
    } cibs_cmd_t;

    typedef struct packed {
        logic more;       // the next window is not empty
        logic hit;        // the probed row matches the key
    } cibs_sts_t;

    function automatic logic [ID_W-1:0] pick_column(
        input logic [SEL_W-1:0] sel,
        input logic [ID_W-1:0]  first_val,
        input logic [ID_W-1:0]  second_val,
        input logic [ID_W-1:0]  third_val
    );
        logic [ID_W-1:0] res;
        unique case (sel)
            COL_FIRST:  res = first_val;
            COL_SECOND: res = second_val;
            default:    res = third_val;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/cross_id_binary_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-identifier binary search: top level
// Sorted three-column identifier table with binary-search lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_valid/s_ready. A load item (s_cmd low) writes
//   one row at s_slot in the cycle it is accepted and gives no result. A
//   lookup item searches rows 0 to min(entry_count, TABLE_DEPTH)-1 in the key column and gives
//   one result item on m_valid/m_ready: found with the result column of the
//   matching row, or not found with a zero value.
//   A lookup reads the column memories through their single read port,
//   once per probe of the search; no new item is accepted until its
//   result has moved into the output register.
//   Write the registers on cfg_we only while the block is idle; the block itself does not enforce this.
//   Reset clears the controller and the registers; the table holds
//   whatever was loaded and has no clearing pass.
//   A result waits in the output register while the receiver stalls; the
//   next item is accepted meanwhile, and a later lookup holds its finished
//   result until the output register is free.
// ----------------------------------------------------------------------------
`include "cross_id_binary_search_defines.svh"

module cross_id_binary_search #(
    parameter int TABLE_DEPTH = cibs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cibs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cibs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [cibs_pkg::SLOT_W-1:0]     s_slot,
    input  logic [cibs_pkg::ID_W-1:0]       s_first_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_second_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_third_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_search_key,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [cibs_pkg::ID_W-1:0]       m_result_value
);
    import cibs_pkg::*;

    logic [CFG_DATA_W-1:0] entry_count_reg;
    logic [CFG_DATA_W-1:0] entry_count_next;
    logic [SEL_W-1:0]      key_column_reg;
    logic [SEL_W-1:0]      key_column_next;
    logic [SEL_W-1:0]      result_column_reg;
    logic [SEL_W-1:0]      result_column_next;

    cibs_cmd_t ctrl_cmd;
    cibs_sts_t dp_sts;

    always_comb begin
        entry_count_next   = entry_count_reg;
        key_column_next    = key_column_reg;
        result_column_next = result_column_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ENTRY_COUNT:   entry_count_next   = cfg_wdata;
                CFG_KEY_COLUMN:    key_column_next    = cfg_wdata[SEL_W-1:0];
                CFG_RESULT_COLUMN: result_column_next = cfg_wdata[SEL_W-1:0];
                default: begin
                    entry_count_next = entry_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg   <= '0;
            key_column_reg    <= '0;
            result_column_reg <= '0;
        end else begin
            entry_count_reg   <= entry_count_next;
            key_column_reg    <= key_column_next;
            result_column_reg <= result_column_next;
        end
    end

    cibs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (dp_sts),
        .cmd     (ctrl_cmd)
    );

    cibs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .cmd               (ctrl_cmd),
        .sts               (dp_sts),
        .cfg_entry_count   (entry_count_reg),
        .cfg_key_column    (key_column_reg),
        .cfg_result_column (result_column_reg),
        .s_slot            (s_slot),
        .s_first_id        (s_first_id),
        .s_second_id       (s_second_id),
        .s_third_id        (s_third_id),
        .s_search_key      (s_search_key),
        .m_found           (m_found),
        .m_result_value    (m_result_value)
    );

    // A miss always reports a zero value.
    `CIBS_ASSERT_IMP(a_miss_value_zero, m_valid && !m_found, m_result_value == '0, "miss with nonzero value")
    // A load item never produces a result.
    `CIBS_ASSERT_NXT(a_load_no_result, s_valid && s_ready && (s_cmd == CMD_LOAD) && !m_valid, !m_valid, "load produced a result")
    // A result appears only after the controller finished a lookup.
    `CIBS_ASSERT_IMP(a_result_from_done, $rose(m_valid), $past(ctrl_cmd.out_load), "result without a finished lookup")

endmodule

@@ rtl/cibs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-identifier binary search: controller
// Sequences load and lookup items and owns the handshake on both channels.
// ----------------------------------------------------------------------------
module cibs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_cmd,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  cibs_pkg::cibs_sts_t sts,
    output cibs_pkg::cibs_cmd_t cmd
);
    import cibs_pkg::*;

    cibs_state_t state_reg;
    cibs_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_cmd == CMD_LOOKUP)) begin
                    state_next = sts.more ? ST_PROBE : ST_DONE;
                end
            end
            ST_PROBE: begin
                if (sts.hit || !sts.more) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // No item is taken while reset is held.
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready      = aresetn;
                cmd.load_row = aresetn && s_valid && (s_cmd == CMD_LOAD);
                cmd.start    = aresetn && s_valid && (s_cmd == CMD_LOOKUP);
            end
            ST_PROBE: begin
                cmd.step = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/cibs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-identifier binary search: datapath
// Three column memories, the search window, the key compare and the
// result registers.
// ----------------------------------------------------------------------------
module cibs_datapath #(
    parameter int TABLE_DEPTH = cibs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            aclk,
    input  cibs_pkg::cibs_cmd_t             cmd,
    output cibs_pkg::cibs_sts_t             sts,
    input  logic [cibs_pkg::CFG_DATA_W-1:0] cfg_entry_count,
    input  logic [cibs_pkg::SEL_W-1:0]      cfg_key_column,
    input  logic [cibs_pkg::SEL_W-1:0]      cfg_result_column,
    input  logic [cibs_pkg::SLOT_W-1:0]     s_slot,
    input  logic [cibs_pkg::ID_W-1:0]       s_first_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_second_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_third_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_search_key,
    output logic                            m_found,
    output logic [cibs_pkg::ID_W-1:0]       m_result_value
);
    import cibs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [ID_W-1:0] first_mem  [TABLE_DEPTH];
    logic [ID_W-1:0] second_mem [TABLE_DEPTH];
    logic [ID_W-1:0] third_mem  [TABLE_DEPTH];

    logic [ID_W-1:0]   rd_first_reg;
    logic [ID_W-1:0]   rd_second_reg;
    logic [ID_W-1:0]   rd_third_reg;
    logic [ID_W-1:0]   key_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic [CNT_W-1:0]  lo_next;
    logic [CNT_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  hi_next;
    logic [CNT_W-1:0]  mid_reg;
    logic [CNT_W-1:0]  mid_next;
    logic              res_found_reg;
    logic [ID_W-1:0]   res_value_reg;
    logic              m_found_reg;
    logic [ID_W-1:0]   m_value_reg;

    logic [CNT_W-1:0]  count_sat;
    logic [ID_W-1:0]   probe_key;
    logic [ID_W-1:0]   probe_result;
    logic              key_lt;
    logic              key_gt;
    logic              hit;
    logic              more;
    logic              slot_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign count_sat = (32'(cfg_entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(cfg_entry_count);

    assign probe_key    = pick_column(cfg_key_column, rd_first_reg, rd_second_reg,
                                      rd_third_reg);
    assign probe_result = pick_column(cfg_result_column, rd_first_reg, rd_second_reg,
                                      rd_third_reg);

    assign key_lt = key_reg < probe_key;
    assign key_gt = key_reg > probe_key;
    assign hit    = cmd.step && !key_lt && !key_gt;

    // Window is [lo, hi) over rows; the probe is the lower middle of it.
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        priority if (cmd.start) begin
            lo_next = '0;
            hi_next = count_sat;
        end else if (cmd.step && key_lt) begin
            hi_next = mid_reg;
        end else if (cmd.step && key_gt) begin
            lo_next = CNT_W'(mid_reg + CNT_W'(1));
        end
    end

    assign more     = lo_next < hi_next;
    assign mid_next = CNT_W'(lo_next + ((hi_next - lo_next - CNT_W'(1)) >> 1));
    assign rd_addr  = mid_next[ADDR_W-1:0];

    assign slot_ok = 32'(s_slot) < TABLE_DEPTH;
    assign wr_addr = ADDR_W'(s_slot);

    always_ff @(posedge aclk) begin
        if (cmd.load_row && slot_ok) begin
            first_mem[wr_addr]  <= s_first_id;
            second_mem[wr_addr] <= s_second_id;
            third_mem[wr_addr]  <= s_third_id;
        end
        rd_first_reg  <= first_mem[rd_addr];
        rd_second_reg <= second_mem[rd_addr];
        rd_third_reg  <= third_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (cmd.start) begin
            key_reg <= s_search_key;
        end
        if ((cmd.start || cmd.step) && (hit || !more)) begin
            res_found_reg <= hit;
            res_value_reg <= hit ? probe_result : '0;
        end
        if (cmd.out_load) begin
            m_found_reg <= res_found_reg;
            m_value_reg <= res_value_reg;
        end
    end

    assign sts.more       = more;
    assign sts.hit        = hit;
    assign m_found        = m_found_reg;
    assign m_result_value = m_value_reg;

endmodule

@@ sim/cibs_lookup_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-identifier binary search: lookup checker
// Watches the register port and both item channels. It keeps its own copy of
// the three identifier columns and of the registers. For every accepted
// lookup it replays the binary search to work out the expected answer, and it
// compares each answer leaving the block with the oldest one still waiting.
// ----------------------------------------------------------------------------
module cibs_lookup_checker #(
    parameter int DEPTH = cibs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cibs_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cibs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [cibs_pkg::SLOT_W-1:0]     s_slot,
    input  logic [cibs_pkg::ID_W-1:0]       s_first_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_second_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_third_id,
    input  logic [cibs_pkg::ID_W-1:0]       s_search_key,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_found,
    input  logic [cibs_pkg::ID_W-1:0]       m_result_value,
    output int                              mismatches,
    output int                              outstanding
);
    import cibs_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] value;
    } answer_t;

    logic [ID_W-1:0]       id_rows [0:2][0:DEPTH-1];
    logic [CFG_DATA_W-1:0] entry_limit;
    logic [SEL_W-1:0]      key_sel;
    logic [SEL_W-1:0]      ret_sel;
    answer_t               pending_answers [$];

    // Selector codes other than the first two pick the third column.
    function automatic logic [ID_W-1:0] column_at(input logic [SEL_W-1:0] sel, input int row);
        case (sel)
            COL_FIRST:  return id_rows[0][row];
            COL_SECOND: return id_rows[1][row];
            default:    return id_rows[2][row];
        endcase
    endfunction

    function automatic answer_t search_table(input logic [ID_W-1:0] key);
        answer_t         ans;
        int              lo;
        int              hi;
        int              mid;
        logic [ID_W-1:0] probe;
        ans = '0;
        lo  = 0;
        hi  = (entry_limit > DEPTH) ? DEPTH : int'(entry_limit);
        // Inclusive window [lo, hi-1], probed at its lower middle.
        while (lo < hi) begin
            mid   = lo + (hi - 1 - lo) / 2;
            probe = column_at(key_sel, mid);
            if (key < probe) begin
                hi = mid;
            end else if (key > probe) begin
                lo = mid + 1;
            end else begin
                ans.found = 1'b1;
                ans.value = column_at(ret_sel, mid);
                break;
            end
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            entry_limit = '0;
            key_sel     = COL_FIRST;
            ret_sel     = COL_FIRST;
            pending_answers.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result item with none awaited: found=%0b value=%h",
                                 $realtime, m_found, m_result_value);
                    mismatches++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_found !== want.found || m_result_value !== want.value) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%0t: lookup answer wrong: expected found=%0b value=%h, got found=%0b value=%h",
                                     $realtime, want.found, want.value, m_found, m_result_value);
                        mismatches++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ENTRY_COUNT:   entry_limit = cfg_wdata;
                    CFG_KEY_COLUMN:    key_sel = cfg_wdata[SEL_W-1:0];
                    CFG_RESULT_COLUMN: ret_sel = cfg_wdata[SEL_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_LOAD) begin
                    if (s_slot < DEPTH) begin
                        id_rows[0][s_slot] = s_first_id;
                        id_rows[1][s_slot] = s_second_id;
                        id_rows[2][s_slot] = s_third_id;
                    end
                end else begin
                    pending_answers.push_back(search_table(s_search_key));
                end
            end
        end
        outstanding = pending_answers.size();
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cross-identifier binary search: testbench top
// Loads sorted, duplicated and unsorted tables, switches the count and the
// column selectors between phases, and fires hit, near-miss and random
// lookups with random idling on both channels. The checker beside the block
// predicts every answer; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import cibs_pkg::*;

    localparam int DEPTH         = DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int FILL_AT       = 500;
    localparam int CALM_ITEMS    = 1400;
    localparam int SETTLE_CYCLES = 20;
    localparam int COUNT_MAX     = 2 ** CFG_DATA_W - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [SEL_W-1:0]     COL_THIRD = 2'd2;
    localparam logic [SEL_W-1:0]     COL_ALIAS = 2'd3;
    localparam logic [ID_W-1:0]      ID_MAX    = {ID_W{1'b1}};
    localparam logic [ID_W-1:0]      STRIDE    = 63'h0800_0000_0000_0000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = CMD_LOAD;
    logic [SLOT_W-1:0]     s_slot = '0;
    logic [ID_W-1:0]       s_first_id = '0;
    logic [ID_W-1:0]       s_second_id = '0;
    logic [ID_W-1:0]       s_third_id = '0;
    logic [ID_W-1:0]       s_search_key = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_found;
    logic [ID_W-1:0]       m_result_value;
    int                    mismatches;
    int                    outstanding;

    int                    gap_pct = 0;
    int                    stall_pct = 0;
    int                    stall_left = 0;
    int                    random_items = 0;
    int                    big_phases = 0;
    bit                    counting = 1'b0;
    bit                    filled = 1'b0;
    logic [ID_W-1:0]       shadow [0:2][0:DEPTH-1];
    bit                    written [0:DEPTH-1];
    logic [CFG_DATA_W-1:0] cur_count = '0;
    logic [SEL_W-1:0]      cur_key_sel = COL_FIRST;

    cross_id_binary_search dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_slot         (s_slot),
        .s_first_id     (s_first_id),
        .s_second_id    (s_second_id),
        .s_third_id     (s_third_id),
        .s_search_key   (s_search_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_result_value (m_result_value)
    );

    cibs_lookup_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_slot         (s_slot),
        .s_first_id     (s_first_id),
        .s_second_id    (s_second_id),
        .s_third_id     (s_third_id),
        .s_search_key   (s_search_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_result_value (m_result_value),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver stalls come in bursts of random length that hold ready low.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ID_W-1:0];
    endfunction

    function automatic int col_of(input logic [SEL_W-1:0] sel);
        if (sel == COL_FIRST)
            return 0;
        if (sel == COL_SECOND)
            return 1;
        return 2;
    endfunction

    // Length of the run of written rows starting at row zero; a lookup may
    // only search that far, so no probe lands on a row never written.
    function automatic int prefix_len();
        int k;
        k = 0;
        while (k < DEPTH && written[k])
            k++;
        return k;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next item follows without a gap.
    task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input logic [ID_W-1:0] c0, input logic [ID_W-1:0] c1,
                             input logic [ID_W-1:0] c2, input logic [ID_W-1:0] key);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_cmd        = cmd;
        s_slot       = slot;
        s_first_id   = c0;
        s_second_id  = c1;
        s_third_id   = c2;
        s_search_key = key;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
        if (cmd == CMD_LOAD) begin
            shadow[0][slot] = c0;
            shadow[1][slot] = c1;
            shadow[2][slot] = c2;
            written[slot]   = 1'b1;
        end
        if (counting)
            random_items++;
    endtask

    task automatic load_row(input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] c0,
                            input logic [ID_W-1:0] c1, input logic [ID_W-1:0] c2);
        send_item(CMD_LOAD, slot, c0, c1, c2, rand_id());
    endtask

    task automatic lookup(input logic [ID_W-1:0] key);
        send_item(CMD_LOOKUP, SLOT_W'($urandom_range(0, DEPTH - 1)),
                  rand_id(), rand_id(), rand_id(), key);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_ENTRY_COUNT)
            cur_count = data;
        else if (idx == CFG_KEY_COLUMN)
            cur_key_sel = data[SEL_W-1:0];
    endtask

    // Waits until every lookup has answered, then lets a trailing load finish.
    task automatic settle();
        s_valid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Ordered tables rise in all three columns at once, so any key column
    // sees a sorted table; about one step in eight repeats the last value.
    task automatic fill_rows(input int n, input bit ordered);
        logic [ID_W-1:0] v [0:2];
        for (int c = 0; c < 3; c++)
            v[c] = rand_id() >> 4;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!ordered)
                    v[c] = rand_id();
                else if (r != 0 && $urandom_range(0, 7) != 0)
                    v[c] = v[c] + (rand_id() >> 23) + 1;
            end
            load_row(SLOT_W'(r), v[0], v[1], v[2]);
        end
    endtask

    task automatic random_lookup();
        logic [ID_W-1:0] key;
        int              eff;
        int              pick;
        eff  = (cur_count > DEPTH) ? DEPTH : int'(cur_count);
        pick = $urandom_range(0, 9);
        if (pick < 8 && eff > 0) begin
            key = shadow[col_of(cur_key_sel)][$urandom_range(0, eff - 1)];
            if (pick >= 6)
                key = $urandom_range(0, 1) ? key + 1 : key - 1;
        end else if (pick == 9) begin
            key = $urandom_range(0, 1) ? ID_MAX : '0;
        end else begin
            key = rand_id();
        end
        lookup(key);
    endtask

    task automatic run_phase();
        int                    n;
        int                    p;
        bit                    rewrite;
        logic [CFG_DATA_W-1:0] count;
        settle();
        if (random_items >= CALM_ITEMS) begin
            gap_pct   = 0;
            stall_pct = 0;
        end else begin
            gap_pct   = 20 * $urandom_range(0, 3);
            stall_pct = 20 * $urandom_range(0, 3);
        end
        n       = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 24);
        p       = prefix_len();
        rewrite = !(big_phases > 0 || (p == DEPTH && $urandom_range(0, 3) == 0));
        if (rewrite && n > p)
            p = n;
        if (big_phases == 2) begin
            count = CFG_DATA_W'(DEPTH);
        end else if (big_phases == 1) begin
            count = CFG_DATA_W'($urandom_range(DEPTH + 1, COUNT_MAX));
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: count = CFG_DATA_W'(rewrite ? n : p);
                6, 7:             count = CFG_DATA_W'($urandom_range(0, p));
                8:                count = CFG_DATA_W'(p);
                default:          count = (p == DEPTH)
                                          ? CFG_DATA_W'($urandom_range(DEPTH, COUNT_MAX))
                                          : CFG_DATA_W'(p);
            endcase
        end
        if (big_phases > 0)
            big_phases--;
        write_reg(CFG_ENTRY_COUNT, count);
        write_reg(CFG_KEY_COLUMN, CFG_DATA_W'($urandom_range(0, 3)));
        write_reg(CFG_RESULT_COLUMN, CFG_DATA_W'($urandom_range(0, 3)));
        if (rewrite)
            fill_rows(n, $urandom_range(0, 7) != 0);
        repeat ($urandom_range(4, 30)) begin
            if ($urandom_range(0, 9) == 0)
                load_row(SLOT_W'($urandom_range(0, DEPTH - 1)), rand_id(), rand_id(), rand_id());
            else
                random_lookup();
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // An empty table answers every lookup with a miss.
        write_reg(CFG_ENTRY_COUNT, '0);
        write_reg(CFG_KEY_COLUMN, CFG_DATA_W'(COL_FIRST));
        write_reg(CFG_RESULT_COLUMN, CFG_DATA_W'(COL_FIRST));
        lookup(ID_MAX);
        lookup('0);

        // Eight rows from all zeros up to all ones, plus the highest slot.
        load_row('0, '0, '0, '0);
        for (int i = 1; i < 7; i++)
            load_row(SLOT_W'(i), STRIDE * i, STRIDE * i + 5, STRIDE * i + 9);
        load_row(SLOT_W'(7), ID_MAX, ID_MAX, ID_MAX);
        load_row({SLOT_W{1'b1}}, rand_id(), rand_id(), rand_id());
        settle();
        write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(8));
        write_reg(CFG_RESULT_COLUMN, CFG_DATA_W'(COL_THIRD));
        lookup('0);
        lookup(ID_MAX);
        lookup(STRIDE * 3);
        lookup(STRIDE * 3 + 1);
        lookup(ID_W'(1));

        // Selector code three behaves as the third column on both sides.
        settle();
        write_reg(CFG_KEY_COLUMN, CFG_DATA_W'(COL_ALIAS));
        write_reg(CFG_RESULT_COLUMN, CFG_DATA_W'(COL_ALIAS));
        lookup(STRIDE * 2 + 9);
        settle();
        write_reg(CFG_KEY_COLUMN, CFG_DATA_W'(COL_SECOND));
        write_reg(CFG_RESULT_COLUMN, CFG_DATA_W'(COL_FIRST));
        lookup(STRIDE * 4 + 5);

        // A write to the unmapped index must leave every register alone.
        settle();
        write_reg(CFG_SPARE, '1);
        lookup(STRIDE * 5 + 5);
        settle();
        write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(1));
        lookup('0);
        lookup(STRIDE + 5);

        counting = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            // Once the whole table is written, counts up to and past the
            // depth become legal; the next two phases use them.
            if (!filled && random_items >= FILL_AT) begin
                settle();
                counting = 1'b0;
                fill_rows(DEPTH, 1'b1);
                counting   = 1'b1;
                filled     = 1'b1;
                big_phases = 2;
            end
            run_phase();
        end
        settle();

        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
